/* rtl/pcx_planar_rle_line_decoder_assert.svh */
// assertion macros shared by the planar pcx line decoder modules
`ifndef PCX_PLANAR_RLE_LINE_DECODER_ASSERT_SVH
`define PCX_PLANAR_RLE_LINE_DECODER_ASSERT_SVH
`ifndef SYNTH
`define PCX_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define PCX_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
        else $error(msg);
`else
`define PCX_ASSERT(name, clk, rst_n, prop, msg)
`define PCX_ASSERT_NEXT(name, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/pcx_prl_pkg.sv */
// shared constants, types and register codes of the planar pcx line decoder
package pcx_prl_pkg;

    localparam int MAX_LINE_PIXELS  = 1024;
    localparam int PLANE_COUNT      = 4;
    localparam int PIXELS_PER_GROUP = 16;

    // line store geometry: one byte of one plane per row (eight pixels)
    localparam int LINE_ROWS = (MAX_LINE_PIXELS + 7) / 8;
    localparam int ROW_W     = $clog2(LINE_ROWS);
    localparam int FILL_W    = $clog2(LINE_ROWS + 1);
    localparam int PLANE_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
    localparam int RP_W      = $clog2(PLANE_COUNT + 1);
    localparam int RAM_AW    = PLANE_W + ROW_W;
    localparam int RAM_DEPTH = 1 << RAM_AW;
    localparam int RAM_DW    = 8;

    localparam int PIX_W   = $clog2(MAX_LINE_PIXELS + 1);
    localparam int GRP_K_W = $clog2(PIXELS_PER_GROUP + 1);
    localparam int POS_W   = 12;
    localparam int CLAMP_W = 13;

    localparam logic [POS_W:0]       POS_LIMIT  = (POS_W + 1)'(MAX_LINE_PIXELS);
    localparam logic [CLAMP_W-1:0]   PIX_LIMIT  = CLAMP_W'(MAX_LINE_PIXELS);
    localparam logic [PLANE_W-1:0]   PLANE_LAST = PLANE_W'(PLANE_COUNT - 1);
    localparam logic [RP_W-1:0]      RP_END     = RP_W'(PLANE_COUNT);
    localparam logic [GRP_K_W-1:0]   GROUP_FULL = GRP_K_W'(PIXELS_PER_GROUP);

    // field widths
    localparam int BYTE_W = 8;
    localparam int BPL_W  = 8;
    localparam int PPL_W  = 11;
    localparam int LCNT_W = 17;
    localparam int LINE_W = 16;
    localparam int GIDX_W = 6;
    localparam int WORD_W = 64;
    localparam int VCNT_W = 5;
    localparam int TIMES_W = 6;

    localparam logic [BYTE_W-1:0] RUN_PREFIX = 8'hC0;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PLANE_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_LINE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT           = 2'd2;

    localparam logic [BPL_W-1:0]  BPL_RESET  = 8'd80;
    localparam logic [PPL_W-1:0]  PPL_RESET  = 11'd640;
    localparam logic [LCNT_W-1:0] LCNT_RESET = 17'd350;

    typedef struct packed {
        logic [BPL_W-1:0]  bytes_per_plane_line;
        logic [PPL_W-1:0]  pixels_per_line;
        logic [LCNT_W-1:0] line_count;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [TIMES_W-1:0] times;
    } t_cmd;

    typedef struct packed {
        logic [LINE_W-1:0] line_index;
        logic [GIDX_W-1:0] group_index;
        logic [WORD_W-1:0] pixel_group;
        logic [VCNT_W-1:0] valid_count;
        logic              last_of_line;
        logic              last_of_image;
    } t_result;

endpackage

/* rtl/pcx_prl_ram.sv */
// generic single write port ram with registered read
module pcx_prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pcx_prl_fifo.sv */
// short command queue between the byte parser and the line builder
`include "pcx_planar_rle_line_decoder_assert.svh"
module pcx_prl_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pcx_prl_pkg::t_cmd   i_cmd,
    input  logic                i_pop,
    output pcx_prl_pkg::t_cmd   o_cmd,
    output logic                o_empty,
    output logic                o_full
);

    pcx_prl_pkg::t_cmd r_mem [pcx_prl_pkg::QUEUE_DEPTH];
    logic [pcx_prl_pkg::QPTR_W-1:0] r_wr;
    logic [pcx_prl_pkg::QPTR_W-1:0] r_rd;
    logic [pcx_prl_pkg::QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == pcx_prl_pkg::QCNT_W'(pcx_prl_pkg::QUEUE_DEPTH));

    `PCX_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "command pushed into full queue")
    `PCX_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty, "command popped from empty queue")

endmodule

/* rtl/pcx_prl_front.sv */
// byte parser: splits run prefixes from data bytes and queues write commands
module pcx_prl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [pcx_prl_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                                i_full,
    output logic                                o_stall,
    output logic                                o_push,
    output pcx_prl_pkg::t_cmd                   o_cmd
);

    logic                               r_run_pending;
    logic [pcx_prl_pkg::TIMES_W-1:0]    r_run_length;
    logic                               w_accept;
    logic                               w_prefix;

    assign w_accept = i_valid && !i_full;
    assign w_prefix = (i_data_byte >= pcx_prl_pkg::RUN_PREFIX);

    // a byte right after a prefix is always data, whatever its value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_pending <= 1'b0;
            r_run_length  <= '0;
        end else if (w_accept) begin
            if (r_run_pending) begin
                r_run_pending <= 1'b0;
            end else if (w_prefix) begin
                r_run_pending <= 1'b1;
                r_run_length  <= i_data_byte[pcx_prl_pkg::TIMES_W-1:0];
            end
        end
    end

    assign o_stall    = i_full;
    assign o_push     = w_accept && (r_run_pending || !w_prefix);
    assign o_cmd.data = i_data_byte;
    assign o_cmd.times = r_run_pending ? r_run_length : pcx_prl_pkg::TIMES_W'(1);

endmodule

/* rtl/pcx_prl_back.sv */
// line builder: writes plane bytes into the line store and streams out pixel groups
`include "pcx_planar_rle_line_decoder_assert.svh"
module pcx_prl_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pcx_prl_pkg::t_cfg       i_cfg,
    input  logic                    i_empty,
    input  pcx_prl_pkg::t_cmd       i_cmd,
    output logic                    o_pop,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output pcx_prl_pkg::t_result    o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_READ  = 4'b0100,
        S_SHIFT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [pcx_prl_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [pcx_prl_pkg::PLANE_W-1:0]  r_plane, n_plane;
    logic [pcx_prl_pkg::LCNT_W-1:0]   r_line, n_line;
    logic                             r_done, n_done;
    logic [pcx_prl_pkg::FILL_W-1:0]   r_fill [pcx_prl_pkg::PLANE_COUNT];
    logic [pcx_prl_pkg::FILL_W-1:0]   n_fill [pcx_prl_pkg::PLANE_COUNT];
    logic [pcx_prl_pkg::BYTE_W-1:0]   r_byte, n_byte;
    logic [pcx_prl_pkg::TIMES_W-1:0]  r_left, n_left;

    logic [pcx_prl_pkg::PIX_W-1:0]    r_n, n_n;
    logic                             r_last_img, n_last_img;
    logic [pcx_prl_pkg::PIX_W-1:0]    r_pix, n_pix;
    logic [pcx_prl_pkg::PIX_W-1:0]    r_grp, n_grp;
    logic [pcx_prl_pkg::GRP_K_W-1:0]  r_k, n_k;
    logic [pcx_prl_pkg::WORD_W-1:0]   r_word, n_word;
    logic [2:0]                       r_bit, n_bit;
    logic [pcx_prl_pkg::RP_W-1:0]     r_rp, n_rp;
    logic                             r_rd_pend, n_rd_pend;
    logic                             r_rd_ok, n_rd_ok;
    logic [pcx_prl_pkg::PLANE_W-1:0]  r_rd_plane, n_rd_plane;
    logic [pcx_prl_pkg::RAM_DW-1:0]   r_rowbuf [pcx_prl_pkg::PLANE_COUNT];
    logic [pcx_prl_pkg::RAM_DW-1:0]   n_rowbuf [pcx_prl_pkg::PLANE_COUNT];

    pcx_prl_pkg::t_result             r_out, n_out;
    logic                             r_ov;

    logic                             w_ram_we;
    logic [pcx_prl_pkg::RAM_AW-1:0]   w_ram_waddr;
    logic [pcx_prl_pkg::RAM_AW-1:0]   w_ram_raddr;
    logic [pcx_prl_pkg::RAM_DW-1:0]   w_ram_rdata;

    logic [pcx_prl_pkg::ROW_W-1:0]    w_wrow;
    logic [pcx_prl_pkg::ROW_W-1:0]    w_rrow;
    logic [pcx_prl_pkg::PLANE_W-1:0]  w_rplane;
    logic                             w_in_store;
    logic                             w_plane_end;
    logic [pcx_prl_pkg::PIX_W-1:0]    w_n;
    logic                             w_last_img;
    logic [3:0]                       w_pixel;
    logic                             w_grp_end;
    logic                             w_pix_last;
    logic                             w_out_free;
    logic                             w_load;
    logic                             w_finish;
    logic                             w_fin_last;
    logic                             w_pop;

    assign w_wrow      = pcx_prl_pkg::ROW_W'(r_pos >> 3);
    assign w_rrow      = pcx_prl_pkg::ROW_W'(r_pix >> 3);
    assign w_rplane    = r_rp[pcx_prl_pkg::PLANE_W-1:0];
    assign w_in_store  = ({1'b0, r_pos} < pcx_prl_pkg::POS_LIMIT);
    assign w_plane_end = (r_pos >= pcx_prl_pkg::POS_W'({i_cfg.bytes_per_plane_line, 3'b000}));
    assign w_last_img  = (({1'b0, r_line} + 18'd1) >= {1'b0, i_cfg.line_count});
    assign w_n = ({2'b00, i_cfg.pixels_per_line} > pcx_prl_pkg::PIX_LIMIT)
               ? pcx_prl_pkg::PIX_W'(pcx_prl_pkg::MAX_LINE_PIXELS)
               : pcx_prl_pkg::PIX_W'(i_cfg.pixels_per_line);
    assign w_grp_end  = ((r_k + 1'b1) == pcx_prl_pkg::GROUP_FULL) || w_pix_last;
    assign w_pix_last = ((r_pix + 1'b1) == r_n);
    assign w_out_free = !r_ov || !i_out_stall;

    // current pixel: one bit of each plane byte, msb first
    always_comb begin
        w_pixel = '0;
        for (int p = 0; p < pcx_prl_pkg::PLANE_COUNT; p++) begin
            w_pixel[p] = r_rowbuf[p][3'd7 - r_bit];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_plane    = r_plane;
        n_line     = r_line;
        n_done     = r_done;
        n_fill     = r_fill;
        n_byte     = r_byte;
        n_left     = r_left;
        n_n        = r_n;
        n_last_img = r_last_img;
        n_pix      = r_pix;
        n_grp      = r_grp;
        n_k        = r_k;
        n_word     = r_word;
        n_bit      = r_bit;
        n_rp       = r_rp;
        n_rd_pend  = 1'b0;
        n_rd_ok    = r_rd_ok;
        n_rd_plane = r_rd_plane;
        n_rowbuf   = r_rowbuf;
        n_out      = r_out;
        w_ram_we    = 1'b0;
        w_ram_waddr = {r_plane, w_wrow};
        w_ram_raddr = {w_rplane, w_rrow};
        w_load     = 1'b0;
        w_finish   = 1'b0;
        w_fin_last = r_last_img;
        w_pop      = 1'b0;

        // plane byte returned by the store, zero where not written this line
        if (r_rd_pend) begin
            n_rowbuf[r_rd_plane] = r_rd_ok ? w_ram_rdata : '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    w_pop = 1'b1;
                    if (!r_done) begin
                        n_byte  = i_cmd.data;
                        n_left  = i_cmd.times;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_left != '0) begin
                    if (w_in_store) begin
                        w_ram_we        = 1'b1;
                        n_fill[r_plane] = pcx_prl_pkg::FILL_W'(w_wrow) + 1'b1;
                        n_pos           = r_pos + pcx_prl_pkg::POS_W'(8);
                        n_left          = r_left - 1'b1;
                    end else begin
                        // rest of the run falls off the store
                        n_pos  = r_pos + pcx_prl_pkg::POS_W'({r_left, 3'b000});
                        n_left = '0;
                    end
                end else begin
                    n_state = S_IDLE;
                    if (w_plane_end) begin
                        n_pos = '0;
                        if (r_plane == pcx_prl_pkg::PLANE_LAST) begin
                            n_plane    = '0;
                            n_n        = w_n;
                            n_last_img = w_last_img;
                            n_pix      = '0;
                            n_grp      = '0;
                            n_k        = '0;
                            n_word     = '0;
                            n_rp       = '0;
                            if (w_n == '0) begin
                                w_finish   = 1'b1;
                                w_fin_last = w_last_img;
                            end else begin
                                n_state = S_READ;
                            end
                        end else begin
                            n_plane = r_plane + 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                if (r_rp == pcx_prl_pkg::RP_END) begin
                    n_state = S_SHIFT;
                    n_bit   = '0;
                end else begin
                    n_rd_pend  = 1'b1;
                    n_rd_plane = w_rplane;
                    n_rd_ok    = (pcx_prl_pkg::FILL_W'(w_rrow) < r_fill[w_rplane]);
                    n_rp       = r_rp + 1'b1;
                end
            end
            S_SHIFT: begin
                if (!w_grp_end || w_out_free) begin
                    for (int j = 0; j < pcx_prl_pkg::PIXELS_PER_GROUP; j++) begin
                        if (r_k == pcx_prl_pkg::GRP_K_W'(j)) begin
                            n_word[pcx_prl_pkg::WORD_W-1-4*j -: 4] = w_pixel;
                        end
                    end
                    n_pix = r_pix + 1'b1;
                    n_k   = r_k + 1'b1;
                    n_bit = r_bit + 1'b1;
                    if (w_grp_end) begin
                        w_load              = 1'b1;
                        n_out.line_index    = r_line[pcx_prl_pkg::LINE_W-1:0];
                        n_out.group_index   = pcx_prl_pkg::GIDX_W'(r_grp);
                        n_out.pixel_group   = n_word;
                        n_out.valid_count   = pcx_prl_pkg::VCNT_W'(r_k)
                                            + pcx_prl_pkg::VCNT_W'(1);
                        n_out.last_of_line  = w_pix_last;
                        n_out.last_of_image = w_pix_last && r_last_img;
                        n_word = '0;
                        n_k    = '0;
                        n_grp  = r_grp + 1'b1;
                    end
                    if (w_pix_last) begin
                        w_finish = 1'b1;
                        n_state  = S_IDLE;
                    end else if (r_bit == 3'd7) begin
                        n_rp    = '0;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of line: empty the store by dropping the fill counts
        if (w_finish) begin
            for (int p = 0; p < pcx_prl_pkg::PLANE_COUNT; p++) begin
                n_fill[p] = '0;
            end
            n_line = r_line + 1'b1;
            if (w_fin_last) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_plane   <= '0;
            r_line    <= '0;
            r_done    <= 1'b0;
            r_rd_pend <= 1'b0;
            r_ov      <= 1'b0;
            for (int p = 0; p < pcx_prl_pkg::PLANE_COUNT; p++) begin
                r_fill[p] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_plane   <= n_plane;
            r_line    <= n_line;
            r_done    <= n_done;
            r_rd_pend <= n_rd_pend;
            r_fill    <= n_fill;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_left     <= n_left;
        r_n        <= n_n;
        r_last_img <= n_last_img;
        r_pix      <= n_pix;
        r_grp      <= n_grp;
        r_k        <= n_k;
        r_word     <= n_word;
        r_bit      <= n_bit;
        r_rp       <= n_rp;
        r_rd_ok    <= n_rd_ok;
        r_rd_plane <= n_rd_plane;
        r_rowbuf   <= n_rowbuf;
        r_out      <= n_out;
    end

    pcx_prl_ram #(
        .WIDTH (pcx_prl_pkg::RAM_DW),
        .DEPTH (pcx_prl_pkg::RAM_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_byte),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_pop       = w_pop;
    assign o_out_valid = r_ov;
    assign o_result    = r_out;

    `PCX_ASSERT(a_no_write_after_image, i_clk, i_rst_n, r_done |-> !w_ram_we, "line store written after image end")
    `PCX_ASSERT(a_row_ready_for_shift, i_clk, i_rst_n, (r_state == S_SHIFT) |-> !r_rd_pend, "pixel shift before plane bytes arrived")
    `PCX_ASSERT(a_image_end_on_line_end, i_clk, i_rst_n, (r_ov && r_out.last_of_image) |-> r_out.last_of_line, "image end flagged inside a line")
    `PCX_ASSERT_NEXT(a_line_steps_once, i_clk, i_rst_n, w_finish, (r_line == $past(r_line) + 17'd1), "line counter did not advance at line end")

endmodule

/* rtl/pcx_planar_rle_line_decoder.sv */
// top level of the planar pcx run-length line decoder
//
// input channel: one encoded pcx byte per request on i_data_byte, taken when
// i_valid is high and o_stall is low. a byte of 0xc0 or above announces a run
// whose count is in its low six bits; the next byte is the data repeated.
// output channel: one request per group of up to sixteen 4-bit pixels, held in an
// output register until taken (o_valid high and i_stall low).
// config port: write i_cfg_data to register i_cfg_index when i_cfg_we is high;
// only while the decoder is idle.
// throughput: the parser takes a byte per cycle into a 4-deep command queue
// while the queue is not full; the line builder takes one command at a time and
// makes one line store write per pixel byte that falls inside the store.
// a line flush reads the line store (one write port, one read port) one plane
// row per cycle, then shifts out one pixel per cycle while the output register
// is free to take each finished group.
// reset: registers return to 80 / 640 / 350, the store reads empty at once
// (per-plane fill counts, no clearing sweep). a stall on the output only holds
// the flush; the parser keeps taking bytes until the queue fills.
module pcx_planar_rle_line_decoder (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // encoded byte stream
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [pcx_prl_pkg::BYTE_W-1:0]          i_data_byte,
    // pixel groups
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [pcx_prl_pkg::LINE_W-1:0]          o_line_index,
    output logic [pcx_prl_pkg::GIDX_W-1:0]          o_group_index,
    output logic [pcx_prl_pkg::WORD_W-1:0]          o_pixel_group,
    output logic [pcx_prl_pkg::VCNT_W-1:0]          o_valid_count,
    output logic                                    o_last_of_line,
    output logic                                    o_last_of_image,
    // register writes
    input  logic                                    i_cfg_we,
    input  logic [pcx_prl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pcx_prl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    pcx_prl_pkg::t_cfg      r_cfg;
    pcx_prl_pkg::t_cmd      w_push_cmd;
    pcx_prl_pkg::t_cmd      w_head_cmd;
    pcx_prl_pkg::t_result   w_result;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_empty;
    logic                   w_full;

    // configuration registers, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_plane_line <= pcx_prl_pkg::BPL_RESET;
            r_cfg.pixels_per_line      <= pcx_prl_pkg::PPL_RESET;
            r_cfg.line_count           <= pcx_prl_pkg::LCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcx_prl_pkg::CFG_BYTES_PER_PLANE_LINE: begin
                    r_cfg.bytes_per_plane_line <= i_cfg_data[pcx_prl_pkg::BPL_W-1:0];
                end
                pcx_prl_pkg::CFG_PIXELS_PER_LINE: begin
                    r_cfg.pixels_per_line <= i_cfg_data[pcx_prl_pkg::PPL_W-1:0];
                end
                pcx_prl_pkg::CFG_LINE_COUNT: begin
                    r_cfg.line_count <= i_cfg_data[pcx_prl_pkg::LCNT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front: byte parsing, run prefix bookkeeping
    pcx_prl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (w_full),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // decouples parsing from the slower store writes and line flushes
    pcx_prl_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // back: plane writes, line flush, output register
    pcx_prl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_result    (w_result)
    );

    assign o_line_index    = w_result.line_index;
    assign o_group_index   = w_result.group_index;
    assign o_pixel_group   = w_result.pixel_group;
    assign o_valid_count   = w_result.valid_count;
    assign o_last_of_line  = w_result.last_of_line;
    assign o_last_of_image = w_result.last_of_image;

endmodule
